[hw/rtl/bfe_pkg.sv]
// Shared types, constants and the CRC-8 step for the frame escape encoder.
// Used by the front, queue and back modules; no dependencies.
package bfe_pkg;

    localparam logic [7:0] ESC_PREFIX   = 8'hA9;
    localparam logic [7:0] ESC_SYN_CODE = 8'h01;
    localparam logic [7:0] ESC_A9_CODE  = 8'h00;
    localparam logic [7:0] CRC_POLY     = 8'h9B;

    localparam logic [7:0] SRC_ADDR_RESET = 8'h00;
    localparam logic [7:0] SYNC_RESET     = 8'hAA;

    // Configuration register indexes
    localparam logic REG_SRC_ADDR = 1'b0;
    localparam logic REG_SYNC     = 1'b1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;   // frame opens with this byte: send address first
    } entry_t;

    typedef struct packed {
        logic [7:0] source_address;
        logic [7:0] sync_symbol;
    } cfg_t;

    // One line byte through the CRC, MSB first, data bit entering bit 0.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc;
        d = b;
        for (int i = 0; i < 8; i++) begin
            fb = c[7];
            c  = {c[6:0], d[7]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hw/rtl/bfe_front.sv]
// Front end: configuration registers, input transfer and frame-start tagging.
// Depends on bfe_pkg.
module bfe_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_wdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            q_push,
    output bfe_pkg::entry_t q_entry,
    output bfe_pkg::cfg_t   cfg
);

    logic         in_frame_reg;
    logic         in_frame_next;
    logic [7:0]   src_addr_reg;
    logic [7:0]   sync_reg;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign q_entry.data  = s_tdata;
    assign q_entry.last  = s_tlast;
    assign q_entry.first = !in_frame_reg;

    assign cfg.source_address = src_addr_reg;
    assign cfg.sync_symbol    = sync_reg;

    always_comb begin
        in_frame_next = in_frame_reg;
        if (q_push) begin
            in_frame_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            src_addr_reg <= bfe_pkg::SRC_ADDR_RESET;
            sync_reg     <= bfe_pkg::SYNC_RESET;
        end else begin
            in_frame_reg <= in_frame_next;
            if (cfg_we) begin
                case (cfg_index)
                    bfe_pkg::REG_SRC_ADDR: src_addr_reg <= cfg_wdata;
                    bfe_pkg::REG_SYNC:     sync_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

[hw/rtl/bfe_queue.sv]
// Short register queue between front and back of the frame encoder.
// Depends on bfe_pkg.
module bfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bfe_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output bfe_pkg::entry_t head
);

    bfe_pkg::entry_t                mem_reg [bfe_pkg::QDEPTH];
    logic [bfe_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bfe_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [bfe_pkg::QCNT_W-1:0]     count_reg;
    logic [bfe_pkg::QCNT_W-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == bfe_pkg::QCNT_W'(bfe_pkg::QDEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hw/rtl/bfe_back.sv]
// Back end: byte sequencer that emits address, escaped data and escaped CRC,
// one line byte per cycle into the output register unless stalled. Depends on bfe_pkg.
module bfe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  bfe_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  bfe_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    localparam logic [2:0] ST_ADDR  = 3'd0;
    localparam logic [2:0] ST_DATA  = 3'd1;
    localparam logic [2:0] ST_DATA2 = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_CRC2  = 3'd4;

    bfe_pkg::entry_t cur_reg;
    logic            active_reg;
    logic [2:0]      step_reg;
    logic [2:0]      step_next;
    logic [7:0]      crc_reg;
    logic [7:0]      crc_next;
    logic            m_tvalid_reg;
    logic [7:0]      m_tdata_reg;
    logic            m_tuser_reg;
    logic            m_tlast_reg;

    logic [7:0]      byte_out;
    logic            crc_flag;
    logic            end_flag;
    logic            finish;
    logic            emit;
    logic            data_syn;
    logic            data_esc;
    logic            crc_syn;
    logic            crc_esc;

    assign emit  = active_reg && (!m_tvalid_reg || m_tready);
    assign q_pop = q_valid && (!active_reg || (emit && finish));

    assign data_syn = (cur_reg.data == cfg.sync_symbol);
    assign data_esc = data_syn || (cur_reg.data == bfe_pkg::ESC_PREFIX);
    assign crc_syn  = (crc_reg == cfg.sync_symbol);
    assign crc_esc  = crc_syn || (crc_reg == bfe_pkg::ESC_PREFIX);

    always_comb begin
        byte_out  = cur_reg.data;
        crc_flag  = 1'b0;
        end_flag  = 1'b0;
        finish    = 1'b0;
        crc_next  = crc_reg;
        step_next = step_reg;
        case (step_reg)
            ST_ADDR: begin
                byte_out  = cfg.source_address;
                crc_next  = bfe_pkg::crc_update(8'h00, byte_out);
                step_next = ST_DATA;
            end
            ST_DATA: begin
                byte_out = data_esc ? bfe_pkg::ESC_PREFIX : cur_reg.data;
                crc_next = bfe_pkg::crc_update(crc_reg, byte_out);
                if (data_esc) begin
                    step_next = ST_DATA2;
                end else if (cur_reg.last) begin
                    step_next = ST_CRC;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_DATA2: begin
                byte_out = data_syn ? bfe_pkg::ESC_SYN_CODE : bfe_pkg::ESC_A9_CODE;
                crc_next = bfe_pkg::crc_update(crc_reg, byte_out);
                if (cur_reg.last) begin
                    step_next = ST_CRC;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_CRC: begin
                // hold the CRC while its escape code is still to go
                byte_out = crc_esc ? bfe_pkg::ESC_PREFIX : crc_reg;
                crc_flag = 1'b1;
                if (crc_esc) begin
                    step_next = ST_CRC2;
                end else begin
                    end_flag = 1'b1;
                    finish   = 1'b1;
                    crc_next = 8'h00;
                end
            end
            ST_CRC2: begin
                byte_out = crc_syn ? bfe_pkg::ESC_SYN_CODE : bfe_pkg::ESC_A9_CODE;
                crc_flag = 1'b1;
                end_flag = 1'b1;
                finish   = 1'b1;
                crc_next = 8'h00;
            end
            default: begin
                finish = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            step_reg     <= ST_ADDR;
            crc_reg      <= 8'h00;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                crc_reg      <= crc_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // a new queue entry takes over the sequencer as the current one finishes
            if (q_pop) begin
                active_reg <= 1'b1;
                step_reg   <= q_head.first ? ST_ADDR : ST_DATA;
            end else if (emit) begin
                step_reg <= step_next;
                if (finish) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_out;
            m_tuser_reg <= crc_flag;
            m_tlast_reg <= end_flag;
        end
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[hw/rtl/bus_frame_escape_crc_encoder.sv]
// Frame encoder with byte stuffing and CRC-8 (poly 0x9B) for a serial bus.
// Instantiates bfe_front, bfe_queue and bfe_back; depends on bfe_pkg.
//
// Usage:
//   s_ channel: one raw message byte per transfer, s_tlast marks the final
//   byte of a message. m_ channel: one line byte per transfer; m_tuser is set
//   on the bytes of the escaped CRC, m_tlast on the last byte of the frame.
//   The first byte of a frame is preceded by the source address register.
//   Configuration: cfg_we with cfg_index 0 (source address) or 1 (SYN value);
//   write only while no frame byte is in flight.
// Timing:
//   The back sequencer puts one line byte out per cycle unless m_tready
//   stalls it; an input byte gives 1 to 5 line bytes (plain 1, escaped 2,
//   plus 1 for the address at frame start, plus 1 or 2 for the CRC on the
//   last byte). Each byte passes the queue, entry and output registers.
//   A four-entry queue lets input transfers continue while the back stalls.
// Reset: aresetn low clears the queue, the frame state and the output valid;
//   registers return to address 0x00 and SYN 0xAA.
// Stall: with m_tready low the output byte holds; once the queue fills,
//   s_tready drops until the receiver takes bytes again.
module bus_frame_escape_crc_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] line_byte
    output logic       m_tuser,    // [0] is_crc
    output logic       m_tlast
);

    bfe_pkg::entry_t push_entry;
    bfe_pkg::entry_t head;
    bfe_pkg::cfg_t   cfg;
    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;

    bfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry),
        .cfg       (cfg)
    );

    bfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .valid      (q_valid),
        .head       (head)
    );

    bfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hw/rtl/bfe_checker.sv]
// Port-level checks for the frame encoder, bound to the top level.
// Depends only on the top-level ports.
module bfe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled output byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    // The frame always closes on a CRC byte
    a_end_on_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end outside the CRC");

    // After a frame end the next byte is the address, never a CRC byte
    a_no_crc_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tuser))
        else $error("CRC byte right after frame end");

    // Reset clears the output valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind bus_frame_escape_crc_encoder bfe_checker u_bfe_checker (.*);
